@@ hw/rtl/avt_pkg.sv @@
// Shared types and constants for the affine vertex transform unit.
package avt_pkg;

   // Field widths of the request and response words
   localparam int COORD_W = 32;
   localparam int IDX_W   = 4;
   localparam int ELEMS   = 16;

   // Request kinds
   localparam logic REQ_LOAD      = 1'b0;
   localparam logic REQ_TRANSFORM = 1'b1;

   // Per-stage load enables handed from the pipeline control to each row lane
   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
      logic ld4;
   } stage_ctl_type;

endpackage

@@ hw/rtl/avt_if.sv @@
// Valid/ready channels for request and response words.
interface avt_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 req_type;
   logic [avt_pkg::IDX_W-1:0]            elem_index;
   logic signed [avt_pkg::COORD_W-1:0]   elem_value;
   logic signed [avt_pkg::COORD_W-1:0]   point_x;
   logic signed [avt_pkg::COORD_W-1:0]   point_y;
   logic signed [avt_pkg::COORD_W-1:0]   point_z;

   modport source (output valid, req_type, elem_index, elem_value, point_x, point_y, point_z,
                   input ready);
   modport sink   (input valid, req_type, elem_index, elem_value, point_x, point_y, point_z,
                   output ready);
endinterface

interface avt_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [avt_pkg::COORD_W-1:0]   out_x;
   logic signed [avt_pkg::COORD_W-1:0]   out_y;
   logic signed [avt_pkg::COORD_W-1:0]   out_z;
   logic                                 overflow;

   modport source (output valid, out_x, out_y, out_z, overflow, input ready);
   modport sink   (input valid, out_x, out_y, out_z, overflow, output ready);
endinterface

@@ hw/rtl/affine_vertex_transform_unit.sv @@
// Top level of the 4x4 matrix vertex transform unit.
// A request word either loads one element of a column-major 4x4 matrix
// (index = row + 4*column, signed fixed point with FRAC_BITS fraction bits,
// identity after reset) or transforms a point (x, y, z, 1). Loads give no
// response word; each transform gives one with the x, y and z rows applied,
// floored by FRAC_BITS, clamped to 32 bits, and overflow set when any
// coordinate clamped. The unit accepts one word per cycle unless the
// stages are stalled; a transform passes through four register stages
// (snapshot, 32x32 multiply, three-way sum, shift and clamp), the multiply
// stage setting the clock. A transform sees every load accepted before it.
// Backpressure on the response stalls the stages, bubbles are squeezed out.
module affine_vertex_transform_unit #(
   parameter int FRAC_BITS = 16
) (
   input logic    clock,
   input logic    reset,
   avt_req_if.sink   req_word,
   avt_rsp_if.source rsp_word
);

   localparam int CW = avt_pkg::COORD_W;
   localparam logic [CW-1:0] ONE_VAL = CW'(1) << FRAC_BITS;

   // Matrix store, column-major
   logic [CW-1:0] matrix_ff [avt_pkg::ELEMS];

   // Stage valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   logic accept;
   logic load_acc;
   logic xform_acc;
   avt_pkg::stage_ctl_type ctl;

   logic signed [CW-1:0] coord [3];
   logic                 sat [3];

   // Ready ripples back from the response side
   assign rdy4 = !v4_ff || rsp_word.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_word.ready = rdy1;
   assign accept    = req_word.valid && rdy1;
   assign load_acc  = accept && (req_word.req_type == avt_pkg::REQ_LOAD);
   assign xform_acc = accept && (req_word.req_type == avt_pkg::REQ_TRANSFORM);

   assign ctl.ld1 = rdy1;
   assign ctl.ld2 = rdy2;
   assign ctl.ld3 = rdy3;
   assign ctl.ld4 = rdy4;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= xform_acc;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // Hold the matrix; reset to identity, write one element per load word
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < avt_pkg::ELEMS; i++) begin
            // Diagonal elements have equal row and column
            matrix_ff[i] <= (i[1:0] == i[3:2]) ? ONE_VAL : '0;
         end
      end else if (load_acc) begin
         matrix_ff[req_word.elem_index] <= req_word.elem_value;
      end
   end

   // One lane per output row
   for (genvar r = 0; r < 3; r++) begin : g_row
      avt_row_dot #(
         .FRAC_BITS (FRAC_BITS)
      ) u_row (
         .clock   (clock),
         .ctl     (ctl),
         .elem_x  (matrix_ff[r]),
         .elem_y  (matrix_ff[r + 4]),
         .elem_z  (matrix_ff[r + 8]),
         .elem_w  (matrix_ff[r + 12]),
         .point_x (req_word.point_x),
         .point_y (req_word.point_y),
         .point_z (req_word.point_z),
         .coord   (coord[r]),
         .sat     (sat[r])
      );
   end

   // Drive the response word
   assign rsp_word.valid    = v4_ff;
   assign rsp_word.out_x    = coord[0];
   assign rsp_word.out_y    = coord[1];
   assign rsp_word.out_z    = coord[2];
   assign rsp_word.overflow = sat[0] || sat[1] || sat[2];

endmodule

@@ hw/rtl/avt_row_dot.sv @@
// One matrix row lane: snapshot, three products, sum, floor shift, translation add and saturate.
module avt_row_dot #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  avt_pkg::stage_ctl_type               ctl,
   input  logic signed [avt_pkg::COORD_W-1:0]   elem_x,
   input  logic signed [avt_pkg::COORD_W-1:0]   elem_y,
   input  logic signed [avt_pkg::COORD_W-1:0]   elem_z,
   input  logic signed [avt_pkg::COORD_W-1:0]   elem_w,
   input  logic signed [avt_pkg::COORD_W-1:0]   point_x,
   input  logic signed [avt_pkg::COORD_W-1:0]   point_y,
   input  logic signed [avt_pkg::COORD_W-1:0]   point_z,
   output logic signed [avt_pkg::COORD_W-1:0]   coord,
   output logic                                 sat
);

   localparam int CW     = avt_pkg::COORD_W;
   localparam int PROD_W = 2 * CW;
   localparam int SUM_W  = PROD_W + 2;
   localparam int TOT_W  = SUM_W + 1;

   // Stage 1: row elements and point, frozen at acceptance
   logic signed [CW-1:0]     mat_ff [3];
   logic signed [CW-1:0]     pnt_ff [3];
   logic signed [CW-1:0]     w1_ff;

   // Stage 2: full-precision products
   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [PROD_W-1:0] prod_in [3];
   logic signed [CW-1:0]     w2_ff;

   // Stage 3: exact sum
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [CW-1:0]     w3_ff;

   // Stage 4: shifted, offset and clamped coordinate
   logic signed [SUM_W-1:0]  shift_val;
   logic signed [TOT_W-1:0]  tot;
   logic                     sat_pos;
   logic                     sat_neg;
   logic signed [CW-1:0]     coord_in;
   logic                     sat_in;
   logic signed [CW-1:0]     coord_ff;
   logic                     sat_ff;

   // Capture the row and point
   always_ff @(posedge clock) begin
      if (ctl.ld1) begin
         mat_ff[0] <= elem_x;
         mat_ff[1] <= elem_y;
         mat_ff[2] <= elem_z;
         w1_ff     <= elem_w;
         pnt_ff[0] <= point_x;
         pnt_ff[1] <= point_y;
         pnt_ff[2] <= point_z;
      end
   end

   // Form the three products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_in[k] = PROD_W'(mat_ff[k]) * PROD_W'(pnt_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld2) begin
         prod_ff <= prod_in;
         w2_ff   <= w1_ff;
      end
   end

   // Sum the products exactly
   assign sum_in = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);

   always_ff @(posedge clock) begin
      if (ctl.ld3) begin
         sum_ff <= sum_in;
         w3_ff  <= w2_ff;
      end
   end

   // Floor-shift, add the translation column, clamp to 32 bits
   always_comb begin
      shift_val = sum_ff >>> FRAC_BITS;
      tot       = TOT_W'(shift_val) + TOT_W'(w3_ff);
      sat_pos   = !tot[TOT_W-1] && (|tot[TOT_W-2:CW-1]);
      sat_neg   = tot[TOT_W-1] && !(&tot[TOT_W-2:CW-1]);
      sat_in    = sat_pos || sat_neg;
      if (sat_pos) begin
         coord_in = {1'b0, {(CW-1){1'b1}}};
      end else if (sat_neg) begin
         coord_in = {1'b1, {(CW-1){1'b0}}};
      end else begin
         coord_in = tot[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld4) begin
         coord_ff <= coord_in;
         sat_ff   <= sat_in;
      end
   end

   assign coord = coord_ff;
   assign sat   = sat_ff;

endmodule
